// File: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication with reset disable
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication with reset disable
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/kpvf_pkg.sv
// package with types and constants of the kalman position and velocity filter
`timescale 1ns / 1ps
`default_nettype none
package kpvf_pkg;

   localparam int unsigned NOISE_W = 31;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned DT_W = 23;
   localparam int unsigned NOISE_RESET = 655;
   localparam int unsigned COV_ADDR_W = 6;

   typedef enum logic {
      OP_PREDICT = 1'b0,
      OP_UPDATE  = 1'b1
   } op_type;

   localparam logic CSR_NOISE_ADDR = 1'b0;

   // operations of the shared arithmetic unit
   typedef enum logic [1:0] {
      ALU_MUL = 2'd0,
      ALU_DIV = 2'd1,
      ALU_NOP = 2'd2
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PRED,
      ST_SLOAD,
      ST_COF_A,
      ST_COF_B,
      ST_COF_W,
      ST_DET,
      ST_DET_W,
      ST_INV,
      ST_INV_W,
      ST_GAIN,
      ST_GAIN_W,
      ST_INNOV,
      ST_STATE,
      ST_STATE_W,
      ST_COVRD,
      ST_COV,
      ST_COV_W,
      ST_COPY,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_div;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic signed [63:0] result;
   } alu_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/kpvf_alu.sv
// shared arithmetic unit: signed multiply with floor shift, iterative divide
`timescale 1ns / 1ps
`default_nettype none
module kpvf_alu #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  kpvf_pkg::alu_req_type     req,
   output kpvf_pkg::alu_rsp_type     rsp
);
   import kpvf_pkg::*;

   typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} alu_st_type;

   alu_st_type st_ff, st_in;
   logic signed [63:0] a_ff, a_in;
   logic signed [63:0] b_ff, b_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        quo_ff, quo_in;
   logic [63:0]        num_ff, num_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [1:0]         part_ff, part_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] res_ff, res_in;
   logic               done_ff, done_in;
   logic [64:0]        trial;
   logic [63:0]        mag_a, mag_b;
   logic signed [48:0] pp;

   // 32x16 partial product over the low or high half of b
   always_comb begin
      if (part_ff == 2'd0) pp = $signed(a_ff[31:0]) * $signed({1'b0, b_ff[15:0]});
      else pp = $signed(a_ff[31:0]) * $signed(b_ff[31:16]);
   end

   assign mag_a = req.a[63] ? 64'(-req.a) : 64'(req.a);
   assign mag_b = req.b[63] ? 64'(-req.b) : 64'(req.b);
   assign trial = {rem_ff, num_ff[63]} - {1'b0, b_ff};

   always_comb begin
      st_in = st_ff; a_in = a_ff; b_in = b_ff; rem_in = rem_ff; quo_in = quo_ff;
      num_in = num_ff; cnt_in = cnt_ff; neg_in = neg_ff; part_in = part_ff;
      acc_in = acc_ff; res_in = res_ff; done_in = 1'b0;
      case (st_ff)
         A_IDLE: begin
            if (req.start) begin
               if (req.is_div) begin
                  st_in = A_DIV; num_in = mag_a; b_in = mag_b; rem_in = '0;
                  quo_in = '0; cnt_in = 7'd64; neg_in = req.a[63] ^ req.b[63];
               end else begin
                  st_in = A_MUL; a_in = req.a; b_in = req.b; part_in = 2'd0;
                  acc_in = '0;
               end
            end
         end
         A_MUL: begin
            if (part_ff == 2'd0) begin
               acc_in = 64'(pp); part_in = 2'd1;
            end else begin
               acc_in = acc_ff + (64'(pp) <<< 16);
               st_in = A_FIX;
            end
         end
         A_FIX: begin
            res_in = acc_ff >>> FRAC_BITS; done_in = 1'b1; st_in = A_IDLE;
         end
         A_DIV: begin
            num_in = num_ff << 1;
            if (!trial[64]) begin
               rem_in = trial[63:0]; quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], num_ff[63]}; quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               st_in = A_IDLE; done_in = 1'b1;
               res_in = neg_ff ? 64'(-$signed(quo_in)) : $signed(quo_in);
            end
         end
         default: st_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= A_IDLE; done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; done_ff <= done_in;
      end
      a_ff <= a_in; b_ff <= b_in; rem_ff <= rem_in; quo_ff <= quo_in; num_ff <= num_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; part_ff <= part_in; acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = res_ff;
endmodule
`default_nettype wire

// File: rtl/kalman_position_velocity_filter_core.sv
// top level of the kalman position and velocity filter
// predict gives no result; update gives a result, with rsp_singular set if singular
// work runs on the shared 32x16 multiplier and the 64-step divider
// throughput: one item at a time, req_ready low while an item is at work
// the result sits in an output register and is held until rsp_ready
// synchronous active-high reset: state zero, covariance identity, noise 655
`timescale 1ns / 1ps
`default_nettype none
module kalman_position_velocity_filter_core #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [31:0] req_axis_x_value,
   input  wire logic [31:0] req_axis_y_value,
   input  wire logic [31:0] req_axis_z_value,
   input  wire logic [22:0] req_time_step,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_pos_x,
   output logic [31:0]      rsp_pos_y,
   output logic [31:0]      rsp_pos_z,
   output logic             rsp_singular,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import kpvf_pkg::*;

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   // configuration register
   logic [30:0] noise_ff;
   always_ff @(posedge clock) begin
      if (reset) noise_ff <= 31'(NOISE_RESET);
      else if (psel && penable && pwrite && paddr == {CSR_NOISE_ADDR, 1'b0})
         noise_ff <= pwdata[30:0];
   end
   assign pready = 1'b1;
   assign prdata = (paddr == {CSR_NOISE_ADDR, 1'b0}) ? {1'b0, noise_ff} : 32'd0;

   // covariance memory plus a shadow for the new matrix
   logic signed [31:0] cov_mem [36];
   logic signed [31:0] newp_mem [36];
   logic [35:0]        cov_written_ff;   // entries not written read as identity
   logic [5:0]         cov_raddr;
   logic signed [31:0] cov_rd_ff;
   logic [5:0]         cov_rd_addr_ff;
   logic signed [31:0] cov_q;
   logic [5:0]         np_raddr;
   logic signed [31:0] np_rd_ff;
   logic               np_we;
   logic [5:0]         np_waddr;
   logic signed [31:0] np_wdata;
   logic               cov_we;

   // small register files
   logic signed [31:0] sv_ff [6];
   logic signed [31:0] s_ff [9];
   logic signed [31:0] cof_ff [9];
   logic signed [31:0] inv_ff [9];
   logic signed [31:0] gain_ff [18];
   logic signed [31:0] innov_ff [3];
   logic signed [31:0] meas_ff [3];
   logic [22:0]        dt_ff;

   state_type st_ff, st_in;
   logic [5:0] i_ff, i_in;     // generic row index
   logic [5:0] j_ff, j_in;
   logic [1:0] k_ff, k_in;
   logic       phase_ff, phase_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [63:0] tmp_ff, tmp_in;
   logic signed [63:0] det_ff, det_in;
   logic       sing_ff, sing_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       issued_ff, issued_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   kpvf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock(clock), .reset(reset), .req(alu_req), .rsp(alu_rsp)
   );

   always_ff @(posedge clock) begin
      cov_rd_ff <= cov_mem[cov_raddr];
      cov_rd_addr_ff <= cov_raddr;
      np_rd_ff <= newp_mem[np_raddr];
      if (np_we) newp_mem[np_waddr] <= np_wdata;
      if (cov_we) cov_mem[np_raddr] <= np_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) cov_written_ff <= '0;
      else if (cov_we) cov_written_ff[np_raddr] <= 1'b1;
   end

   // diagonal entries of the 6x6 matrix
   assign cov_q = cov_written_ff[cov_rd_addr_ff] ? cov_rd_ff :
                  ((cov_rd_addr_ff inside {6'd0, 6'd7, 6'd14, 6'd21, 6'd28, 6'd35}) ?
                   ONE : 32'sd0);

   function automatic logic [1:0] nx(input logic [1:0] v, input logic [1:0] d);
      logic [2:0] t;
      t = 3'(v) + 3'(d);
      return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

   logic [1:0] ci, cj;
   logic [3:0] sidx_a, sidx_b;
   always_comb begin
      ci = i_ff[1:0]; cj = j_ff[1:0];
      if (!phase_ff) begin
         sidx_a = 4'(nx(ci, 2'd1)) * 4'd3 + 4'(nx(cj, 2'd1));
         sidx_b = 4'(nx(ci, 2'd2)) * 4'd3 + 4'(nx(cj, 2'd2));
      end else begin
         sidx_a = 4'(nx(ci, 2'd1)) * 4'd3 + 4'(nx(cj, 2'd2));
         sidx_b = 4'(nx(ci, 2'd2)) * 4'd3 + 4'(nx(cj, 2'd1));
      end
   end

   always_comb begin
      st_in = st_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff; phase_in = phase_ff;
      acc_in = acc_ff; tmp_in = tmp_ff; det_in = det_ff; sing_in = sing_ff;
      rsp_valid_in = rsp_valid_ff; issued_in = issued_ff;
      alu_req = '0; cov_raddr = '0; np_raddr = '0; np_we = 1'b0; np_waddr = '0;
      np_wdata = '0; cov_we = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               i_in = '0; j_in = '0; k_in = '0; phase_in = 1'b0; issued_in = 1'b0;
               acc_in = '0;
               st_in = (req_operation == OP_UPDATE) ? ST_SLOAD : ST_PRED;
            end
         end
         ST_PRED: begin
            // position += floor(v*dt), one axis at a time
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               alu_req.a = 64'(meas_ff[i_ff[1:0]]);
               alu_req.b = 64'({1'b0, dt_ff});
               issued_in = 1'b1;
            end else if (alu_rsp.done) begin
               issued_in = 1'b0;
               if (i_ff == 6'd2) st_in = ST_IDLE;
               else i_in = i_ff + 6'd1;
            end
         end
         ST_SLOAD: begin
            // read P[i][j] for s, captured in the next cycle
            if (!phase_ff) begin
               cov_raddr = 6'(i_ff * 6 + j_ff); phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (j_ff == 6'd2) begin
                  j_in = '0;
                  if (i_ff == 6'd2) begin
                     i_in = '0; st_in = ST_COF_A;
                  end else i_in = i_ff + 6'd1;
               end else j_in = j_ff + 6'd1;
            end
         end
         ST_COF_A, ST_COF_B: begin
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               alu_req.a = 64'(s_ff[sidx_a]);
               alu_req.b = 64'(s_ff[sidx_b]);
               issued_in = 1'b1;
            end else if (alu_rsp.done) begin
               issued_in = 1'b0;
               if (st_ff == ST_COF_A) begin
                  tmp_in = alu_rsp.result; phase_in = 1'b1; st_in = ST_COF_B;
               end else begin
                  tmp_in = tmp_ff - alu_rsp.result; phase_in = 1'b0; st_in = ST_COF_W;
               end
            end
         end
         ST_COF_W: begin
            st_in = ST_COF_A;
            if (j_ff == 6'd2) begin
               j_in = '0;
               if (i_ff == 6'd2) begin
                  i_in = '0; st_in = ST_DET; acc_in = '0;
               end else i_in = i_ff + 6'd1;
            end else j_in = j_ff + 6'd1;
         end
         ST_DET: begin
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               alu_req.a = 64'(s_ff[4'(j_ff)]);
               alu_req.b = 64'(cof_ff[4'(j_ff)]);
               issued_in = 1'b1;
            end else if (alu_rsp.done) begin
               issued_in = 1'b0;
               acc_in = acc_ff + 66'(alu_rsp.result);
               if (j_ff == 6'd2) begin
                  j_in = '0; st_in = ST_DET_W;
               end else j_in = j_ff + 6'd1;
            end
         end
         ST_DET_W: begin
            det_in = acc_ff[63:0];
            sing_in = (acc_ff == '0);
            st_in = (acc_ff == '0) ? ST_OUT : ST_INV;
         end
         ST_INV: begin
            // inv[i][j] = cof[j][i] * 2^F / det
            if (!issued_ff) begin
               alu_req.start = 1'b1; alu_req.is_div = 1'b1;
               alu_req.a = 64'(cof_ff[4'(j_ff) * 4'd3 + 4'(i_ff)]) <<< FRAC_BITS;
               alu_req.b = det_ff;
               issued_in = 1'b1;
            end else if (alu_rsp.done) begin
               issued_in = 1'b0; tmp_in = alu_rsp.result; st_in = ST_INV_W;
            end
         end
         ST_INV_W: begin
            st_in = ST_INV;
            if (j_ff == 6'd2) begin
               j_in = '0;
               if (i_ff == 6'd2) begin
                  i_in = '0; st_in = ST_GAIN; acc_in = '0; k_in = '0; phase_in = 1'b0;
               end else i_in = i_ff + 6'd1;
            end else j_in = j_ff + 6'd1;
         end
         ST_GAIN: begin
            // gain[i][j] = sum_k P[i][k]*inv[k][j]
            if (!phase_ff) begin
               cov_raddr = 6'(i_ff * 6 + 6'(k_ff)); phase_in = 1'b1;
            end else if (!issued_ff) begin
               alu_req.start = 1'b1;
               alu_req.a = 64'(cov_q);
               alu_req.b = 64'(inv_ff[4'(k_ff) * 4'd3 + 4'(j_ff)]);
               issued_in = 1'b1;
            end else if (alu_rsp.done) begin
               issued_in = 1'b0; phase_in = 1'b0;
               acc_in = acc_ff + 66'(alu_rsp.result);
               if (k_ff == 2'd2) begin
                  k_in = '0; st_in = ST_GAIN_W;
               end else k_in = k_ff + 2'd1;
            end
         end
         ST_GAIN_W: begin
            acc_in = '0; st_in = ST_GAIN;
            if (j_ff == 6'd2) begin
               j_in = '0;
               if (i_ff == 6'd5) begin
                  i_in = '0; st_in = ST_INNOV;
               end else i_in = i_ff + 6'd1;
            end else j_in = j_ff + 6'd1;
         end
         ST_INNOV: begin
            st_in = ST_STATE; acc_in = 66'(sv_ff[0]); j_in = '0;
         end
         ST_STATE: begin
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               alu_req.a = 64'(gain_ff[5'(i_ff) * 5'd3 + 5'(j_ff)]);
               alu_req.b = 64'(innov_ff[j_ff[1:0]]);
               issued_in = 1'b1;
            end else if (alu_rsp.done) begin
               issued_in = 1'b0;
               acc_in = acc_ff + 66'(alu_rsp.result);
               if (j_ff == 6'd2) begin
                  j_in = '0; st_in = ST_STATE_W;
               end else j_in = j_ff + 6'd1;
            end
         end
         ST_STATE_W: begin
            st_in = ST_STATE;
            if (i_ff == 6'd5) begin
               i_in = '0; j_in = '0; k_in = '0; st_in = ST_COVRD; phase_in = 1'b0;
            end else begin
               i_in = i_ff + 6'd1; acc_in = 66'(sv_ff[3'(i_ff + 6'd1)]);
            end
         end
         ST_COVRD: begin
            // P[i][j] into acc; i row, j column, k inner
            if (!phase_ff) begin
               cov_raddr = 6'(i_ff * 6 + j_ff); phase_in = 1'b1;
            end else begin
               acc_in = 66'(cov_q); phase_in = 1'b0; k_in = '0; st_in = ST_COV;
            end
         end
         ST_COV: begin
            if (!phase_ff) begin
               cov_raddr = 6'(6'(k_ff) * 6 + j_ff); phase_in = 1'b1;
            end else if (!issued_ff) begin
               alu_req.start = 1'b1;
               alu_req.a = 64'(gain_ff[5'(i_ff) * 5'd3 + 5'(k_ff)]);
               alu_req.b = 64'(cov_q);
               issued_in = 1'b1;
            end else if (alu_rsp.done) begin
               issued_in = 1'b0; phase_in = 1'b0;
               acc_in = acc_ff - 66'(alu_rsp.result);
               if (k_ff == 2'd2) st_in = ST_COV_W;
               else k_in = k_ff + 2'd1;
            end
         end
         ST_COV_W: begin
            np_we = 1'b1; np_waddr = 6'(i_ff * 6 + j_ff); np_wdata = sat32(acc_ff);
            st_in = ST_COVRD;
            if (j_ff == 6'd5) begin
               j_in = '0;
               if (i_ff == 6'd5) begin
                  i_in = '0; st_in = ST_COPY; phase_in = 1'b0;
               end else i_in = i_ff + 6'd1;
            end else j_in = j_ff + 6'd1;
         end
         ST_COPY: begin
            // read shadow at i, write cov in the next cycle
            np_raddr = i_ff;
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               np_raddr = i_ff; cov_we = 1'b0;
               phase_in = 1'b0;
            end
            if (phase_ff) begin
               cov_we = 1'b1;
               if (i_ff == 6'd35) st_in = ST_OUT;
               else i_in = i_ff + 6'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath register writes
   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && req_valid && req_ready) begin
         meas_ff[0] <= req_axis_x_value; meas_ff[1] <= req_axis_y_value;
         meas_ff[2] <= req_axis_z_value; dt_ff <= req_time_step;
      end
      if (st_ff == ST_SLOAD && phase_ff)
         s_ff[4'(i_ff) * 4'd3 + 4'(j_ff)] <=
            sat32(66'(cov_q) + ((i_ff == j_ff) ? 66'({1'b0, noise_ff}) : 66'd0));
      if (st_ff == ST_COF_W) cof_ff[4'(i_ff) * 4'd3 + 4'(j_ff)] <= sat32(66'(tmp_ff));
      if (st_ff == ST_INV_W) inv_ff[4'(i_ff) * 4'd3 + 4'(j_ff)] <= sat32(66'(tmp_ff));
      if (st_ff == ST_GAIN_W) gain_ff[5'(i_ff) * 5'd3 + 5'(j_ff)] <= sat32(acc_ff);
      if (st_ff == ST_INNOV) begin
         innov_ff[0] <= sat32(66'(meas_ff[0]) - 66'(sv_ff[0]));
         innov_ff[1] <= sat32(66'(meas_ff[1]) - 66'(sv_ff[1]));
         innov_ff[2] <= sat32(66'(meas_ff[2]) - 66'(sv_ff[2]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 6; n++) sv_ff[n] <= '0;
      end else if (st_ff == ST_PRED && issued_ff && alu_rsp.done) begin
         sv_ff[i_ff[2:0]] <= sat32(66'(sv_ff[i_ff[2:0]]) + 66'(alu_rsp.result));
         sv_ff[3'(i_ff) + 3'd3] <= meas_ff[i_ff[1:0]];
      end else if (st_ff == ST_STATE_W) begin
         sv_ff[i_ff[2:0]] <= sat32(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rsp_valid_ff <= 1'b0; issued_ff <= 1'b0; phase_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rsp_valid_ff <= rsp_valid_in; issued_ff <= issued_in;
         phase_ff <= phase_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; acc_ff <= acc_in; tmp_ff <= tmp_in;
      det_ff <= det_in; sing_ff <= sing_in;
   end

   // output register, held until taken
   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic        os_ff;
   always_ff @(posedge clock) begin
      if (st_ff == ST_OUT && !rsp_valid_ff) begin
         ox_ff <= sv_ff[0]; oy_ff <= sv_ff[1]; oz_ff <= sv_ff[2]; os_ff <= sing_ff;
      end
   end

   assign req_ready = (st_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = ox_ff;
   assign rsp_pos_y = oy_ff;
   assign rsp_pos_z = oz_ff;
   assign rsp_singular = os_ff;
endmodule
`default_nettype wire

// File: rtl/kpvf_checker.sv
// port-level checker for the filter core and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kpvf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_operation,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [31:0] rsp_pos_x,
   input wire logic pready
);
   import kpvf_pkg::*;

   `CHK_IMPL(a_busy, clock, reset, rsp_valid, !req_ready, "ready while result pending")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pos_x), "result dropped")
   `CHK_NEXT(a_pred, clock, reset, req_valid && req_ready && req_operation == OP_PREDICT, !rsp_valid, "predict gave result")
   `CHK_IMPL(a_prdy, clock, reset, 1'b1, pready, "pready low")
endmodule

bind kalman_position_velocity_filter_core kpvf_checker u_kpvf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_operation(req_operation), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_pos_x(rsp_pos_x), .pready(pready)
);
`default_nettype wire

// File: test/tb.sv
// testbench of the kalman position and velocity filter core
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import kpvf_pkg::*;

   localparam int unsigned FRAC = 16;
   localparam logic [1:0] NOISE_BYTE_ADDR = 2'(4 * CSR_NOISE_ADDR);

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        singular;
   } fused_pos_type;

   // mirror of the filter: state, covariance and noise, plus the positions it should report
   class kalman_tracker;
      longint        st[6];
      longint        cov[36];
      longint        noise;
      fused_pos_type fused_positions[$];
      int            errors;

      function new();
         for (int i = 0; i < 6; i++) st[i] = 0;
         for (int i = 0; i < 36; i++) cov[i] = (i % 7 == 0) ? (longint'(1) << FRAC) : 0;
         noise = NOISE_RESET;
         errors = 0;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // product rounded toward minus infinity
      function longint fxmul(longint a, longint b);
         return (a * b) >>> FRAC;
      endfunction

      function void set_noise(logic [31:0] v);
         noise = longint'(v[30:0]);
      endfunction

      function void note_item(op_type op, logic [31:0] ax, logic [31:0] ay,
                              logic [31:0] az, logic [22:0] dt);
         longint axis[3], s[3][3], cof[3][3], inv[3][3], gain[6][3], innov[3];
         longint newp[36], det, acc;
         fused_pos_type p;
         int i1, i2, j1, j2;
         axis[0] = longint'(signed'(ax));
         axis[1] = longint'(signed'(ay));
         axis[2] = longint'(signed'(az));
         if (op == OP_PREDICT) begin
            for (int i = 0; i < 3; i++) begin
               st[i] = clamp32(st[i] + ((axis[i] * longint'(dt)) >>> FRAC));
               st[3 + i] = axis[i];
            end
            return;
         end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               s[i][j] = clamp32(cov[i * 6 + j] + ((i == j) ? noise : 0));
         for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
               j1 = (j + 1) % 3;
               j2 = (j + 2) % 3;
               cof[i][j] = clamp32(fxmul(s[i1][j1], s[i2][j2]) - fxmul(s[i1][j2], s[i2][j1]));
            end
         end
         det = fxmul(s[0][0], cof[0][0]) + fxmul(s[0][1], cof[0][1])
             + fxmul(s[0][2], cof[0][2]);
         if (det != 0) begin
            // adjugate is the transposed cofactor matrix
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  inv[i][j] = clamp32((cof[j][i] * (longint'(1) << FRAC)) / det);
            for (int i = 0; i < 6; i++)
               for (int j = 0; j < 3; j++) begin
                  acc = 0;
                  for (int k = 0; k < 3; k++) acc += fxmul(cov[i * 6 + k], inv[k][j]);
                  gain[i][j] = clamp32(acc);
               end
            for (int i = 0; i < 3; i++) innov[i] = clamp32(axis[i] - st[i]);
            for (int i = 0; i < 6; i++) begin
               acc = st[i];
               for (int j = 0; j < 3; j++) acc += fxmul(gain[i][j], innov[j]);
               st[i] = clamp32(acc);
            end
            for (int i = 0; i < 6; i++)
               for (int k = 0; k < 6; k++) begin
                  acc = cov[i * 6 + k];
                  for (int j = 0; j < 3; j++) acc -= fxmul(gain[i][j], cov[j * 6 + k]);
                  newp[i * 6 + k] = clamp32(acc);
               end
            cov = newp;
         end
         p.x = st[0][31:0];
         p.y = st[1][31:0];
         p.z = st[2][31:0];
         p.singular = (det == 0);
         fused_positions.push_back(p);
      endfunction

      function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic sg);
         fused_pos_type e;
         if (fused_positions.size() == 0) begin
            $error("result with no item waiting for it");
            errors++;
            return;
         end
         e = fused_positions.pop_front();
         if (x !== e.x) begin
            $error("pos_x expected %h actual %h", e.x, x);
            errors++;
         end
         if (y !== e.y) begin
            $error("pos_y expected %h actual %h", e.y, y);
            errors++;
         end
         if (z !== e.z) begin
            $error("pos_z expected %h actual %h", e.z, z);
            errors++;
         end
         if (sg !== e.singular) begin
            $error("singular expected %b actual %b", e.singular, sg);
            errors++;
         end
      endfunction

      function int pending();
         return fused_positions.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [31:0] req_axis_x_value;
   logic [31:0] req_axis_y_value;
   logic [31:0] req_axis_z_value;
   logic [22:0] req_time_step;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_pos_x;
   logic [31:0] rsp_pos_y;
   logic [31:0] rsp_pos_z;
   logic        rsp_singular;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   kalman_tracker tracker = new();
   bit            no_gaps;
   int            results_seen;

   kalman_position_velocity_filter_core #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_axis_x_value(req_axis_x_value), .req_axis_y_value(req_axis_y_value),
      .req_axis_z_value(req_axis_z_value), .req_time_step(req_time_step),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z), .rsp_singular(rsp_singular),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard, far beyond the slowest legal run
   initial begin
      #150_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function int draw_gap();
      if (no_gaps) return 0;
      return $urandom_range(0, 11);
   endfunction

   // small values keep the filter out of saturation, full range and extremes hit the clamps
   function logic [31:0] pick_axis();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($urandom_range(0, 1310720)) - 32'd655360;
      endcase
   endfunction

   function logic [22:0] pick_step();
      if ($urandom_range(0, 4) == 0) return 23'($urandom_range(0, 4194304));
      return 23'($urandom_range(0, 65536));
   endfunction

   task automatic send_item(op_type op, logic [31:0] ax, logic [31:0] ay,
                            logic [31:0] az, logic [22:0] dt);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_axis_x_value <= ax;
      req_axis_y_value <= ay;
      req_axis_z_value <= az;
      req_time_step    <= dt;
      do @(posedge clock); while (!req_ready);
      tracker.note_item(op, ax, ay, az, dt);
   endtask

   task automatic send_random(int count);
      op_type op;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(0, 1) != 0) ? OP_UPDATE : OP_PREDICT;
         send_item(op, pick_axis(), pick_axis(), pick_axis(), pick_step());
      end
   endtask

   // setup cycle then access cycle; pready is tied high
   task automatic write_noise(logic [31:0] v);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= NOISE_BYTE_ADDR;
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.set_noise(v);
      @(posedge clock);
   endtask

   // all results in, then room for a trailing predict to finish
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // result side: random stall per item, one long hold-off to back the block up
   initial begin
      int stall;
      rsp_ready = 1'b0;
      results_seen = 0;
      @(negedge reset);
      forever begin
         stall = (results_seen == 40) ? 3000 : draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_singular);
   end

   initial begin
      logic [31:0] noise_settings[6];
      noise_settings = '{32'd65536, 32'h7fffffff, 32'd1, 32'd0, 32'd655, 32'd655};
      noise_settings[4] = 32'($urandom_range(1, 32'h7fffffff));
      reset = 1'b1;
      no_gaps = 1'b0;
      req_valid = 1'b0;
      req_operation = OP_PREDICT;
      req_axis_x_value = '0;
      req_axis_y_value = '0;
      req_axis_z_value = '0;
      req_time_step = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: update straight out of reset, clamps, zero and full time step
      send_item(OP_UPDATE, 32'h00010000, 32'hffff0000, 32'h0, 23'd0);
      send_item(OP_PREDICT, 32'h00010000, 32'h00020000, 32'hfffd0000, 23'd0);
      send_item(OP_PREDICT, 32'h00010000, 32'h00020000, 32'hfffd0000, 23'd65536);
      send_item(OP_UPDATE, 32'h00010000, 32'h00020000, 32'hfffd0000, 23'h7fffff);
      send_item(OP_PREDICT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 23'd4194304);
      send_item(OP_PREDICT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 23'd4194304);
      send_item(OP_UPDATE, 32'h80000000, 32'h7fffffff, 32'h80000000, 23'd0);
      send_item(OP_UPDATE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 23'd0);
      send_item(OP_PREDICT, 32'h80000000, 32'h7fffffff, 32'h80000000, 23'd4194303);
      send_item(OP_UPDATE, 32'h0, 32'h0, 32'h0, 23'd0);
      send_item(OP_UPDATE, 32'hffffffff, 32'h00000001, 32'hffffffff, 23'd0);
      send_item(OP_PREDICT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 23'd1);
      send_item(OP_UPDATE, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 23'h2aaaaa);
      drain();

      // zero noise: the register is taken as written
      write_noise(32'd0);
      for (int n = 0; n < 6; n++)
         send_item(OP_UPDATE, 32'h00008000, 32'hffff8000, 32'h00004000, 23'd0);
      drain();

      // a spread of noise settings, some phases without idle gaps
      foreach (noise_settings[p]) begin
         write_noise(noise_settings[p]);
         no_gaps = (p % 3 == 1);
         send_random(p == 0 ? 160 : 180);
         drain();
      end

      repeat (50) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
